[rtl/sddf_pkg.sv]
// Shared types and constants for the signed decimal digit formatter.
`default_nettype none
package sddf_pkg;

  localparam int POSITIONS = 8;
  localparam int POS_W     = 3;
  localparam int DISP_W    = 2;
  localparam int ADDR_W    = 4;
  localparam int CODE_W    = 8;
  localparam int DIGIT_W   = 4;
  localparam int MAG_W     = 32;

  localparam logic [DIGIT_W-1:0] CODE_DASH  = 4'hA;
  localparam logic [DIGIT_W-1:0] CODE_BLANK = 4'hF;
  localparam logic [CODE_W-1:0]  POINT_BIT  = 8'h80;

  // floor(x / 10) = (x * RECIP_TEN) >> RECIP_SHIFT for any 32-bit x
  localparam logic [MAG_W-1:0] RECIP_TEN   = 32'hCCCC_CCCD;
  localparam int               RECIP_SHIFT = 35;

  typedef enum logic [1:0] {
    F_IDLE,
    F_CONV,
    F_PUSH
  } fstate_t;

  typedef struct packed {
    logic [DISP_W-1:0]                 disp;
    logic [POSITIONS-1:0][CODE_W-1:0]  codes;
  } entry_t;

endpackage
`default_nettype wire

[rtl/sddf_ifs.sv]
// Request channel interfaces for the formatter input and digit writes.
`default_nettype none
interface sddf_in_if;
  logic              valid;
  logic              ready;
  logic [1:0]        display_index;
  logic signed [31:0] value;
  logic              blank_leading_zeros;
  logic signed [3:0] point_position;

  modport source (output valid, display_index, value, blank_leading_zeros, point_position,
                  input ready);
  modport sink   (input valid, display_index, value, blank_leading_zeros, point_position,
                  output ready);
endinterface

interface sddf_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] target_display;
  logic [3:0] register_address;
  logic [7:0] digit_code;
  logic       last_write;

  modport source (output valid, target_display, register_address, digit_code, last_write,
                  input ready);
  modport sink   (input valid, target_display, register_address, digit_code, last_write,
                  output ready);
endinterface
`default_nettype wire

[rtl/signed_decimal_digit_formatter.sv]
// The front end turns a taken request into decimal digits and queues the entry; the write
// sequencer then issues one write per cycle while out_ch.ready is high, positions 0 to 7,
// eight writes per request. Request rate is bounded by those eight writes; the divide-by-ten
// unit runs ahead of the write sequencer through a 2-entry queue.
// Reset: synchronous, active low; clears handshake and queue state, no clearing pass.
`default_nettype none
module signed_decimal_digit_formatter #(
  parameter int SHOWN_DIGITS = 6
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  sddf_in_if.sink    in_ch,
  sddf_out_if.source out_ch
);

  sddf_pkg::entry_t f_entry, b_entry;
  logic             f_valid, f_ready;
  logic             b_valid, b_ready;

  sddf_front #(.SHOWN_DIGITS(SHOWN_DIGITS)) u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .q_entry (f_entry),
    .q_valid (f_valid),
    .q_ready (f_ready)
  );

  sddf_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_entry (f_entry),
    .wr_valid (f_valid),
    .wr_ready (f_ready),
    .rd_entry (b_entry),
    .rd_valid (b_valid),
    .rd_ready (b_ready)
  );

  sddf_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_entry (b_entry),
    .q_valid (b_valid),
    .q_ready (b_ready),
    .out_ch  (out_ch)
  );

endmodule
`default_nettype wire

[rtl/sddf_front.sv]
// Front end: takes a request, extracts decimal digits, applies blanking and point.
`default_nettype none
module sddf_front #(
  parameter int SHOWN_DIGITS = 6
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  sddf_in_if.sink            in_ch,
  output sddf_pkg::entry_t   q_entry,
  output logic               q_valid,
  input  wire logic          q_ready
);

  localparam int CNT_W = $clog2(SHOWN_DIGITS + 1);

  sddf_pkg::fstate_t st_r, st_nxt;

  logic [CNT_W-1:0]                 cnt_r;
  logic [sddf_pkg::MAG_W-1:0]       mag_r;
  logic [SHOWN_DIGITS-1:0][sddf_pkg::DIGIT_W-1:0] digits_r;
  logic [sddf_pkg::DISP_W-1:0]      disp_r;
  logic                             neg_r;
  logic                             blank_r;
  logic [3:0]                       pp_r;

  logic                             in_ready;
  logic                             acc;
  logic [2*sddf_pkg::MAG_W-1:0]     prod;
  logic [sddf_pkg::MAG_W-1:0]       quot;
  logic [sddf_pkg::MAG_W-1:0]       rem_full;
  logic [sddf_pkg::MAG_W-1:0]       raw;
  logic [sddf_pkg::MAG_W-1:0]       mag_in;
  logic                             last_digit;

  assign acc        = in_ch.valid && in_ready;
  assign in_ch.ready = in_ready;
  assign raw        = $unsigned(in_ch.value);
  assign mag_in     = raw[sddf_pkg::MAG_W-1] ? (~raw + 32'd1) : raw;
  assign prod       = mag_r * sddf_pkg::RECIP_TEN;
  assign quot       = sddf_pkg::MAG_W'(prod >> sddf_pkg::RECIP_SHIFT);
  assign rem_full   = mag_r - ((quot << 3) + (quot << 1));
  assign last_digit = (cnt_r == CNT_W'(SHOWN_DIGITS - 1));

  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      sddf_pkg::F_IDLE: begin
        if (in_ch.valid) st_nxt = sddf_pkg::F_CONV;
      end
      sddf_pkg::F_CONV: begin
        if (last_digit) st_nxt = sddf_pkg::F_PUSH;
      end
      sddf_pkg::F_PUSH: begin
        if (q_ready) st_nxt = in_ch.valid ? sddf_pkg::F_CONV : sddf_pkg::F_IDLE;
      end
      default: st_nxt = sddf_pkg::F_IDLE;
    endcase
  end

  always_comb begin
    in_ready = 1'b0;
    q_valid  = 1'b0;
    unique case (st_r)
      sddf_pkg::F_IDLE: in_ready = 1'b1;
      sddf_pkg::F_CONV: in_ready = 1'b0;
      sddf_pkg::F_PUSH: begin
        q_valid  = 1'b1;
        in_ready = q_ready;
      end
      default: in_ready = 1'b0;
    endcase
  end

  // blanking scan and point insertion
  always_comb begin
    logic                has_point;
    logic [2:0]          stop;
    logic                blanking;
    logic [sddf_pkg::DIGIT_W-1:0] code;
    has_point = !pp_r[3];
    stop      = has_point ? pp_r[2:0] : 3'd0;
    blanking  = 1'b1;
    q_entry.disp = disp_r;
    for (int p = 0; p < sddf_pkg::POSITIONS; p++) begin
      q_entry.codes[p] = {4'h0, sddf_pkg::CODE_BLANK};
    end
    q_entry.codes[sddf_pkg::POSITIONS-1] =
      {4'h0, (neg_r ? sddf_pkg::CODE_DASH : sddf_pkg::CODE_BLANK)};
    for (int p = SHOWN_DIGITS - 1; p >= 0; p--) begin
      code = digits_r[p];
      if (code != 4'd0 || 3'(p) == stop) blanking = 1'b0;
      if (blank_r && blanking && code == 4'd0) code = sddf_pkg::CODE_BLANK;
      q_entry.codes[p] = {4'h0, code};
    end
    for (int p = 0; p < sddf_pkg::POSITIONS; p++) begin
      if (has_point && pp_r[2:0] == 3'(p)) begin
        q_entry.codes[p] = q_entry.codes[p] | sddf_pkg::POINT_BIT;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= sddf_pkg::F_IDLE;
    end else begin
      st_r <= st_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      cnt_r   <= '0;
      mag_r   <= mag_in;
      disp_r  <= in_ch.display_index;
      neg_r   <= raw[sddf_pkg::MAG_W-1];
      blank_r <= in_ch.blank_leading_zeros;
      pp_r    <= $unsigned(in_ch.point_position);
    end else if (st_r == sddf_pkg::F_CONV) begin
      cnt_r <= cnt_r + CNT_W'(1);
      mag_r <= quot;
      digits_r[SHOWN_DIGITS-1] <= rem_full[sddf_pkg::DIGIT_W-1:0];
      for (int i = 0; i < SHOWN_DIGITS - 1; i++) begin
        digits_r[i] <= digits_r[i+1];
      end
    end
  end

endmodule
`default_nettype wire

[rtl/sddf_queue.sv]
// Two-entry queue between the digit front end and the write sequencer.
`default_nettype none
module sddf_queue (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire sddf_pkg::entry_t  wr_entry,
  input  wire logic              wr_valid,
  output logic                   wr_ready,
  output sddf_pkg::entry_t       rd_entry,
  output logic                   rd_valid,
  input  wire logic              rd_ready
);

  sddf_pkg::entry_t mem_r [2];
  logic       wptr_r, rptr_r;
  logic [1:0] cnt_r;
  logic       push, pop;

  assign wr_ready = (cnt_r != 2'd2);
  assign rd_valid = (cnt_r != 2'd0);
  assign rd_entry = mem_r[rptr_r];
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= 1'b0;
      rptr_r <= 1'b0;
      cnt_r  <= 2'd0;
    end else begin
      if (push) wptr_r <= ~wptr_r;
      if (pop)  rptr_r <= ~rptr_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wptr_r] <= wr_entry;
  end

endmodule
`default_nettype wire

[rtl/sddf_back.sv]
// Back end: issues the eight digit-register writes of each queued entry.
`default_nettype none
module sddf_back (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire sddf_pkg::entry_t  q_entry,
  input  wire logic              q_valid,
  output logic                   q_ready,
  sddf_out_if.source             out_ch
);

  sddf_pkg::entry_t              cur_r;
  logic                          act_r;
  logic [sddf_pkg::POS_W-1:0]    pos_r;
  logic                          last;
  logic                          sent;

  assign last    = (pos_r == sddf_pkg::POS_W'(sddf_pkg::POSITIONS - 1));
  assign sent    = act_r && out_ch.ready;
  assign q_ready = !act_r || (sent && last);

  assign out_ch.valid            = act_r;
  assign out_ch.target_display   = cur_r.disp;
  assign out_ch.register_address = sddf_pkg::ADDR_W'(pos_r) + sddf_pkg::ADDR_W'(1);
  assign out_ch.digit_code       = cur_r.codes[pos_r];
  assign out_ch.last_write       = last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      act_r <= 1'b0;
      pos_r <= '0;
    end else if (q_valid && q_ready) begin
      act_r <= 1'b1;
      pos_r <= '0;
    end else if (sent) begin
      pos_r <= pos_r + sddf_pkg::POS_W'(1);
      if (last) act_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_valid && q_ready) cur_r <= q_entry;
  end

endmodule
`default_nettype wire

[sim/tb_signed_decimal_digit_formatter.sv]
// Testbench for the signed decimal digit formatter: directed and random requests.
`default_nettype none
module tb_signed_decimal_digit_formatter;

  localparam int SHOWN_DIGITS = 6;
  localparam int DRAIN_CYCLES = 32;

  typedef struct packed {
    logic [1:0] disp;
    logic [3:0] addr;
    logic [7:0] code;
    logic       last;
  } digit_write_t;

  logic clk;
  logic rst_n;
  logic src_idle_on;
  logic sink_stall_on;
  int   err_count;

  digit_write_t pending_writes[$];

  sddf_in_if  in_ch();
  sddf_out_if out_ch();

  signed_decimal_digit_formatter #(
    .SHOWN_DIGITS(SHOWN_DIGITS)
  ) DUT (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  initial clk = 1'b0;
  always #4 clk = ~clk;

  initial begin
    #2_000_000;
    $display("FAIL signed_decimal_digit_formatter");
    $finish;
  end

  // Queue the eight digit writes that one request should produce.
  function automatic void format_digits(input logic [1:0] disp, input logic [31:0] value,
                                        input logic blank, input logic [3:0] pp);
    logic [31:0]  mag;
    logic         neg;
    logic         has_point;
    logic         blanking;
    int           stop;
    logic [7:0]   codes[sddf_pkg::POSITIONS];
    digit_write_t w;
    neg       = value[31];
    mag       = neg ? (~value + 32'd1) : value;
    has_point = !pp[3];
    stop      = has_point ? int'(pp[2:0]) : 0;
    for (int p = 0; p < sddf_pkg::POSITIONS; p++)
      codes[p] = {4'h0, sddf_pkg::CODE_BLANK};
    codes[sddf_pkg::POSITIONS-1] = neg ? {4'h0, sddf_pkg::CODE_DASH}
                                       : {4'h0, sddf_pkg::CODE_BLANK};
    for (int p = 0; p < SHOWN_DIGITS; p++) begin
      codes[p] = 8'(mag % 32'd10);
      mag      = mag / 32'd10;
    end
    if (blank) begin
      blanking = 1'b1;
      for (int p = SHOWN_DIGITS - 1; p >= 0; p--) begin
        if (codes[p] != 8'd0 || p == stop)
          blanking = 1'b0;
        if (blanking && codes[p] == 8'd0)
          codes[p] = {4'h0, sddf_pkg::CODE_BLANK};
      end
    end
    for (int p = 0; p < sddf_pkg::POSITIONS; p++) begin
      w.disp = disp;
      w.addr = 4'(p + 1);
      w.code = (has_point && p == int'(pp[2:0])) ? (codes[p] | sddf_pkg::POINT_BIT)
                                                 : codes[p];
      w.last = (p == sddf_pkg::POSITIONS - 1);
      pending_writes.push_back(w);
    end
  endfunction

  task automatic send_request(input logic [1:0] disp, input logic [31:0] value,
                              input logic blank, input logic [3:0] pp);
    while (src_idle_on && $urandom_range(0, 99) < 9) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid               <= 1'b1;
    in_ch.display_index       <= disp;
    in_ch.value               <= value;
    in_ch.blank_leading_zeros <= blank;
    in_ch.point_position      <= pp;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    format_digits(disp, value, blank, pp);
  endtask

  // Digit write checker and sink-side stalls.
  always @(posedge clk) begin
    digit_write_t got;
    digit_write_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got = {out_ch.target_display, out_ch.register_address, out_ch.digit_code,
             out_ch.last_write};
      if (pending_writes.size() == 0) begin
        err_count++;
        if (err_count <= 10)
          $display("unexpected write: disp %0d addr %0d code %h last %0d",
                   got.disp, got.addr, got.code, got.last);
      end else begin
        want = pending_writes.pop_front();
        if (got !== want) begin
          err_count++;
          if (err_count <= 10)
            $display("mismatch: exp disp %0d addr %0d code %h last %0d, ",
                     want.disp, want.addr, want.code, want.last,
                     "got disp %0d addr %0d code %h last %0d",
                     got.disp, got.addr, got.code, got.last);
        end
      end
    end
    out_ch.ready <= !(sink_stall_on && $urandom_range(0, 99) < 9);
  end

  task automatic test_extremes();
    send_request(2'd0, 32'd0, 1'b0, 4'hF);
    send_request(2'd1, 32'd0, 1'b1, 4'hF);
    send_request(2'd2, 32'd1, 1'b1, 4'hF);
    send_request(2'd3, -32'sd1, 1'b1, 4'hF);
    send_request(2'd0, 32'h7FFF_FFFF, 1'b0, 4'd0);
    send_request(2'd1, 32'h8000_0001, 1'b1, 4'd2);
    send_request(2'd2, 32'h8000_0000, 1'b1, 4'hF);
    send_request(2'd3, 32'd999999, 1'b1, 4'd5);
    send_request(2'd0, 32'd1000000, 1'b1, 4'hF);
    send_request(2'd1, -32'sd999999, 1'b0, 4'd1);
    send_request(2'd2, 32'd123456, 1'b1, 4'd4);
  endtask

  // Point handling: no point, point at 0-1, 3, 5-7, far negative codes, zero with high point.
  task automatic test_point_cases();
    send_request(2'd0, 32'd0, 1'b1, 4'd6);
    send_request(2'd1, 32'd0, 1'b1, 4'd7);
    send_request(2'd2, -32'sd1000000, 1'b1, 4'd7);
    send_request(2'd0, 32'd1200, 1'b1, 4'd3);
    send_request(2'd1, 32'd5, 1'b1, 4'd5);
    send_request(2'd2, 32'd0, 1'b1, 4'd0);
    send_request(2'd3, 32'd40, 1'b1, 4'h8);
    send_request(2'd0, 32'd40, 1'b1, 4'hE);
    send_request(2'd1, -32'sd7, 1'b0, 4'd6);
    send_request(2'd2, 32'd1000, 1'b1, 4'd1);
    send_request(2'd0, -32'sd305, 1'b1, 4'd7);
    send_request(2'd1, 32'd90, 1'b0, 4'd7);
  endtask

  task automatic random_requests(input int count);
    logic [31:0] v;
    logic [3:0]  pp;
    for (int i = 0; i < count; i++) begin
      case ($urandom_range(0, 3))
        0:       v = $urandom;
        1:       v = $urandom_range(0, 999);
        2:       v = $urandom_range(0, 1_999_999);
        default: v = $urandom_range(0, 9) * (10 ** $urandom_range(0, 7));
      endcase
      if ($urandom_range(0, 1) == 1)
        v = ~v + 32'd1;
      if ($urandom_range(0, 3) == 0)
        pp = 4'($urandom_range(0, 15));
      else if ($urandom_range(0, 8) == 0)
        pp = 4'hF;
      else
        pp = 4'($urandom_range(0, 7));
      send_request(2'($urandom_range(0, 3)), v, 1'($urandom_range(0, 3) != 0), pp);
    end
  endtask

  task automatic test_random_idling();
    src_idle_on   <= 1'b1;
    sink_stall_on <= 1'b1;
    random_requests(300);
  endtask

  task automatic test_back_to_back();
    src_idle_on   <= 1'b0;
    sink_stall_on <= 1'b0;
    random_requests(100);
  endtask

  initial begin
    err_count                  = 0;
    rst_n                      <= 1'b0;
    src_idle_on                <= 1'b1;
    sink_stall_on              <= 1'b1;
    in_ch.valid                <= 1'b0;
    in_ch.display_index        <= 2'd0;
    in_ch.value                <= 32'd0;
    in_ch.blank_leading_zeros  <= 1'b0;
    in_ch.point_position       <= 4'hF;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_extremes();
    test_point_cases();
    test_random_idling();
    test_back_to_back();
    in_ch.valid <= 1'b0;
    while (pending_writes.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (err_count == 0 && pending_writes.size() == 0)
      $display("PASS signed_decimal_digit_formatter");
    else
      $display("FAIL signed_decimal_digit_formatter");
    $finish;
  end

endmodule
`default_nettype wire
